>>> design/irc_pkg.sv
// Shared types and constants for the IR reflectance conditioner.
`timescale 1ns / 1ps

package irc_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 10;
  localparam int CAL_W       = 11;
  localparam int ERR_W       = 16;
  localparam int Q15_SHIFT   = 15;
  localparam int CHANNELS    = 4;

  // Defaults
  localparam int             MAX_CAL_SAMPLES_DEF = 1024;
  localparam logic [CAL_W-1:0] CAL_SAMPLES_RESET = 11'd16;

  // Channel order
  localparam int CH_FRONT_LEFT  = 0;
  localparam int CH_FRONT_RIGHT = 1;
  localparam int CH_SIDE_LEFT   = 2;
  localparam int CH_SIDE_RIGHT  = 3;

  // Item action codes
  localparam logic ACT_MEASURE   = 1'b0;
  localparam logic ACT_CALIBRATE = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [SAMPLE_BITS-1:0] dark_front_left;
    logic [SAMPLE_BITS-1:0] lit_front_left;
    logic [SAMPLE_BITS-1:0] dark_front_right;
    logic [SAMPLE_BITS-1:0] lit_front_right;
    logic [SAMPLE_BITS-1:0] dark_side_left;
    logic [SAMPLE_BITS-1:0] lit_side_left;
    logic [SAMPLE_BITS-1:0] dark_side_right;
    logic [SAMPLE_BITS-1:0] lit_side_right;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] front_left_level;
    logic [SAMPLE_BITS-1:0] front_right_level;
    logic [SAMPLE_BITS-1:0] side_left_level;
    logic [SAMPLE_BITS-1:0] side_right_level;
    logic signed [ERR_W-1:0] center_error;
    logic                   calibration_done;
  } out_word_t;

endpackage

>>> design/ir_reflectance_conditioner.sv
// Top level: IR channel conditioning, baseline calibration and centering error.
`timescale 1ns / 1ps
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid / in_ready     | in_word  (irc_pkg::in_word_t)
//  out     | output    | out_valid / out_ready   | out_word (irc_pkg::out_word_t)
//  cfg     | input     | cfg_we (no wait)        | cfg_wdata (cal_samples)
//
//  A measure word runs through the serial divider, which forms the centering
//  ratio one bit per cycle. A word that completes calibration then runs
//  four baseline averages on the same divider, one channel after another.
//  One word is in work at a time.
//  Reset (rst, synchronous) clears baselines, sums, count and the sequencer.
//  A finished result waits in the output register; the next word is accepted
//  meanwhile and holds in its last step until the output register frees.

module ir_reflectance_conditioner #(
  parameter int MAX_CAL_SAMPLES = irc_pkg::MAX_CAL_SAMPLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  irc_pkg::in_word_t        in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output irc_pkg::out_word_t       out_word,
  input  logic                     cfg_we,
  input  logic [irc_pkg::CAL_W-1:0] cfg_wdata
);

  import irc_pkg::*;

  // Derived sizes
  localparam int CAL_MAX  = (1 << CAL_W) - 1;
  localparam int NMAX     = (MAX_CAL_SAMPLES < CAL_MAX) ? MAX_CAL_SAMPLES : CAL_MAX;
  localparam int CNT_W    = $clog2(NMAX + 1);
  localparam int SUM_W    = SAMPLE_BITS + ((NMAX > 1) ? $clog2(NMAX) : 1);
  localparam int CTR_W    = SAMPLE_BITS + Q15_SHIFT;
  localparam int NUM_W    = (CTR_W > SUM_W) ? CTR_W : SUM_W;
  localparam int DEN_W    = (SAMPLE_BITS + 1 > CNT_W) ? SAMPLE_BITS + 1 : CNT_W;
  localparam int CH_W     = $clog2(CHANNELS);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_CTR_GO   = 6'b000010,
    S_CTR_WAIT = 6'b000100,
    S_AVG_GO   = 6'b001000,
    S_AVG_WAIT = 6'b010000,
    S_OUT      = 6'b100000
  } state_t;

  function automatic logic [SAMPLE_BITS-1:0] cond_level(
    input logic [SAMPLE_BITS-1:0] dark,
    input logic [SAMPLE_BITS-1:0] lit,
    input logic [SAMPLE_BITS-1:0] base
  );
    logic [SAMPLE_BITS-1:0] v;
    v = (lit > dark) ? (lit - dark) : '0;
    return (v > base) ? (v - base) : '0;
  endfunction

  state_t                  state;
  logic [CAL_W-1:0]        cal_samples;
  logic [SAMPLE_BITS-1:0]  baselines [CHANNELS];
  logic [SUM_W-1:0]        sums      [CHANNELS];
  logic [CNT_W-1:0]        cal_count;
  logic [SAMPLE_BITS-1:0]  lvl       [CHANNELS];
  logic                    done_flag;
  logic [CH_W-1:0]         ch;
  logic signed [ERR_W-1:0] center_err;

  logic                    in_accept;
  logic [SAMPLE_BITS-1:0]  dark      [CHANNELS];
  logic [SAMPLE_BITS-1:0]  lit       [CHANNELS];
  logic [SAMPLE_BITS-1:0]  lvl_next  [CHANNELS];
  logic [SUM_W-1:0]        sums_next [CHANNELS];
  logic [CNT_W-1:0]        count_inc;
  logic [CNT_W-1:0]        n_eff;
  logic                    cal_hit;

  logic                    div_start;
  logic                    div_done;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic [NUM_W-1:0]        div_quot;
  logic                    ctr_neg;
  logic [SAMPLE_BITS-1:0]  ctr_diff;
  logic [ERR_W-1:0]        ctr_mag;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CAL_SAMPLES_RESET;
    end else if (cfg_we) begin
      cal_samples <= cfg_wdata;
    end
  end

  // Effective sample count: zero reads as one, large values saturate
  always_comb begin
    if (cal_samples == '0) begin
      n_eff = CNT_W'(1);
    end else if (cal_samples > CAL_W'(NMAX)) begin
      n_eff = CNT_W'(NMAX);
    end else begin
      n_eff = CNT_W'(cal_samples);
    end
  end

  // Per-channel conditioning with the baselines held before this word
  always_comb begin
    dark[CH_FRONT_LEFT]  = in_word.dark_front_left;
    lit[CH_FRONT_LEFT]   = in_word.lit_front_left;
    dark[CH_FRONT_RIGHT] = in_word.dark_front_right;
    lit[CH_FRONT_RIGHT]  = in_word.lit_front_right;
    dark[CH_SIDE_LEFT]   = in_word.dark_side_left;
    lit[CH_SIDE_LEFT]    = in_word.lit_side_left;
    dark[CH_SIDE_RIGHT]  = in_word.dark_side_right;
    lit[CH_SIDE_RIGHT]   = in_word.lit_side_right;
    for (int c = 0; c < CHANNELS; c++) begin
      lvl_next[c]  = cond_level(dark[c], lit[c], baselines[c]);
      sums_next[c] = sums[c] + SUM_W'(lvl_next[c]);
    end
    count_inc = cal_count + 1'b1;
    cal_hit   = (in_word.action == ACT_CALIBRATE) && (count_inc >= n_eff);
  end

  // Divider operands: centering ratio or one baseline average
  always_comb begin
    ctr_neg  = (lvl[CH_SIDE_LEFT] < lvl[CH_SIDE_RIGHT]);
    ctr_diff = ctr_neg ? (lvl[CH_SIDE_RIGHT] - lvl[CH_SIDE_LEFT])
                       : (lvl[CH_SIDE_LEFT] - lvl[CH_SIDE_RIGHT]);
    if (state == S_AVG_GO) begin
      div_num = NUM_W'(sums[ch]);
      div_den = DEN_W'(n_eff);
    end else begin
      div_num = NUM_W'({ctr_diff, {Q15_SHIFT{1'b0}}});
      div_den = DEN_W'({1'b0, lvl[CH_SIDE_LEFT]} + {1'b0, lvl[CH_SIDE_RIGHT]} + 1'b1);
    end
    div_start = (state == S_CTR_GO) || (state == S_AVG_GO);
    ctr_mag   = div_quot[ERR_W-1:0];
  end

  irc_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequencer and calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cal_count <= '0;
      done_flag <= 1'b0;
      ch        <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        baselines[c] <= '0;
        sums[c]      <= '0;
      end
    end else begin
      // output word leaves on its handshake unless the next one replaces it
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (in_word.action == ACT_CALIBRATE) begin
              for (int c = 0; c < CHANNELS; c++) begin
                sums[c] <= sums_next[c];
              end
              cal_count <= cal_hit ? '0 : count_inc;
            end
            done_flag <= cal_hit;
            ch        <= '0;
            state     <= S_CTR_GO;
          end
        end
        S_CTR_GO: begin
          state <= S_CTR_WAIT;
        end
        S_CTR_WAIT: begin
          if (div_done) begin
            state <= done_flag ? S_AVG_GO : S_OUT;
          end
        end
        S_AVG_GO: begin
          state <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            baselines[ch] <= div_quot[SAMPLE_BITS-1:0];
            sums[ch]      <= '0;
            if (ch == CH_W'(CHANNELS - 1)) begin
              state <= S_OUT;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_AVG_GO;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int c = 0; c < CHANNELS; c++) begin
        lvl[c] <= lvl_next[c];
      end
    end
    if (state == S_CTR_WAIT && div_done) begin
      center_err <= ctr_neg ? signed'(~ctr_mag + 1'b1) : signed'(ctr_mag);
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_word.front_left_level  <= lvl[CH_FRONT_LEFT];
      out_word.front_right_level <= lvl[CH_FRONT_RIGHT];
      out_word.side_left_level   <= lvl[CH_SIDE_LEFT];
      out_word.side_right_level  <= lvl[CH_SIDE_RIGHT];
      out_word.center_error      <= center_err;
      out_word.calibration_done  <= done_flag;
    end
  end

  // Checks
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_CTR_WAIT || state == S_AVG_WAIT))
    else $error("divider finished outside a wait state");

  a_accept_starts_ratio: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_CTR_GO))
    else $error("accepted word did not start the ratio divide");

  a_cal_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && done_flag) |->
      (cal_count == '0 && sums[0] == '0 && sums[1] == '0 &&
       sums[2] == '0 && sums[3] == '0))
    else $error("calibration sums not cleared after baseline load");

endmodule

>>> design/irc_divider.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module irc_divider #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [NUM_W-1:0]  quo;

  logic [DEN_W:0]    trial;
  logic              fits;
  logic [DEN_W:0]    diff;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    fits  = (trial >= {1'b0, den});
    diff  = trial - {1'b0, den};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      // pulse after the last quotient bit
      done <= busy && !start && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top, quotient shifts in the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the IR reflectance conditioner: directed and random sensor rounds.
`timescale 1ns / 1ps

module testbench;
  import irc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CAL_W-1:0] cfg_wdata = '0;

  ir_reflectance_conditioner dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Sensor rounds waiting to be sent and conditioned words still due
  in_word_t  rounds_q[$];
  out_word_t levels_due[$];
  int rounds_total = 0;
  int rounds_sent = 0;
  int results_seen = 0;
  int mismatches = 0;

  // Receiver hold-off state
  int hold_left = 0;
  bit hold_done = 1'b0;
  out_word_t want;

  // Predictor state
  logic [CAL_W-1:0]       cal_reg = CAL_SAMPLES_RESET;
  logic [SAMPLE_BITS-1:0] baseline [CHANNELS] = '{default: '0};
  int unsigned            cal_sum [CHANNELS] = '{default: 0};
  int unsigned            cal_count = 0;

  // Ambient cancel, then baseline removal, each clamped at zero
  function automatic logic [SAMPLE_BITS-1:0] clip_level(logic [SAMPLE_BITS-1:0] dark,
                                                         logic [SAMPLE_BITS-1:0] lit,
                                                         logic [SAMPLE_BITS-1:0] base);
    logic [SAMPLE_BITS-1:0] raw;
    raw = (lit > dark) ? lit - dark : '0;
    return (raw > base) ? raw - base : '0;
  endfunction

  // (l - r) / (l + r + 1) in Q1.15, truncated toward zero
  function automatic logic signed [ERR_W-1:0] centering_q15(logic [SAMPLE_BITS-1:0] l,
                                                            logic [SAMPLE_BITS-1:0] r);
    int unsigned den;
    int unsigned mag;
    den = int'(l) + int'(r) + 1;
    if (l >= r) begin
      mag = ((int'(l) - int'(r)) << Q15_SHIFT) / den;
      return ERR_W'(mag);
    end
    mag = ((int'(r) - int'(l)) << Q15_SHIFT) / den;
    return ERR_W'(0 - mag);
  endfunction

  // Conditioned word for one round; updates baselines and calibration sums
  function automatic out_word_t condition_word(in_word_t w);
    logic [SAMPLE_BITS-1:0] lvl [CHANNELS];
    out_word_t o;
    int unsigned eff;
    lvl[CH_FRONT_LEFT]  = clip_level(w.dark_front_left, w.lit_front_left,
                                     baseline[CH_FRONT_LEFT]);
    lvl[CH_FRONT_RIGHT] = clip_level(w.dark_front_right, w.lit_front_right,
                                     baseline[CH_FRONT_RIGHT]);
    lvl[CH_SIDE_LEFT]   = clip_level(w.dark_side_left, w.lit_side_left,
                                     baseline[CH_SIDE_LEFT]);
    lvl[CH_SIDE_RIGHT]  = clip_level(w.dark_side_right, w.lit_side_right,
                                     baseline[CH_SIDE_RIGHT]);
    o = '0;
    o.front_left_level  = lvl[CH_FRONT_LEFT];
    o.front_right_level = lvl[CH_FRONT_RIGHT];
    o.side_left_level   = lvl[CH_SIDE_LEFT];
    o.side_right_level  = lvl[CH_SIDE_RIGHT];
    o.center_error      = centering_q15(lvl[CH_SIDE_LEFT], lvl[CH_SIDE_RIGHT]);
    if (w.action == ACT_CALIBRATE) begin
      // zero counts as one, oversize saturates
      if (cal_reg == 0) eff = 1;
      else if (cal_reg > MAX_CAL_SAMPLES_DEF) eff = MAX_CAL_SAMPLES_DEF;
      else eff = cal_reg;
      for (int c = 0; c < CHANNELS; c++) cal_sum[c] += lvl[c];
      cal_count++;
      if (cal_count >= eff) begin
        for (int c = 0; c < CHANNELS; c++) begin
          baseline[c] = SAMPLE_BITS'(cal_sum[c] / eff);
          cal_sum[c] = 0;
        end
        cal_count = 0;
        o.calibration_done = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic in_word_t reading_word(logic act, int dfl, int lfl, int dfr, int lfr,
                                            int dsl, int lsl, int dsr, int lsr);
    in_word_t w;
    w.action           = act;
    w.dark_front_left  = SAMPLE_BITS'(dfl);
    w.lit_front_left   = SAMPLE_BITS'(lfl);
    w.dark_front_right = SAMPLE_BITS'(dfr);
    w.lit_front_right  = SAMPLE_BITS'(lfr);
    w.dark_side_left   = SAMPLE_BITS'(dsl);
    w.lit_side_left    = SAMPLE_BITS'(lsl);
    w.dark_side_right  = SAMPLE_BITS'(dsr);
    w.lit_side_right   = SAMPLE_BITS'(lsr);
    return w;
  endfunction

  // One dark/lit pair: extremes, equal pairs, random pairs and small lit-over-dark margins
  task automatic random_pair(output int dark, output int lit);
    case ($urandom_range(9))
      0: begin dark = 0; lit = 1023; end
      1: begin dark = 1023; lit = 0; end
      2: begin dark = $urandom_range(1023); lit = dark; end
      3: begin dark = 0; lit = $urandom_range(1023); end
      4, 5: begin dark = $urandom_range(1023); lit = $urandom_range(1023); end
      default: begin
        dark = $urandom_range(400);
        lit = dark + $urandom_range(300);
      end
    endcase
  endtask

  task automatic offer(in_word_t w);
    rounds_q.push_back(w);
    rounds_total++;
  endtask

  // Wait until every round offered so far has come back
  task automatic drain();
    while (results_seen != rounds_total) @(posedge clk);
  endtask

  task automatic load_cal_samples(logic [CAL_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cal_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_batch(int count, int cal_pct);
    int d [CHANNELS];
    int l [CHANNELS];
    logic act;
    for (int i = 0; i < count; i++) begin
      for (int c = 0; c < CHANNELS; c++) random_pair(d[c], l[c]);
      act = ($urandom_range(99) < cal_pct) ? ACT_CALIBRATE : ACT_MEASURE;
      offer(reading_word(act, d[0], l[0], d[1], l[1], d[2], l[2], d[3], l[3]));
    end
    drain();
  endtask

  // Sender: holds a word until accepted, idles at random outside a steady stretch
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        levels_due.push_back(condition_word(in_word));
        rounds_sent++;
      end
      if (!in_valid || in_ready) begin
        if (rounds_q.size() != 0 &&
            ((rounds_sent >= 300 && rounds_sent < 600) || $urandom_range(99) >= 26)) begin
          in_word <= rounds_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word against the oldest one due
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        results_seen++;
        if (levels_due.size() == 0) begin
          if (mismatches < 10) $display("%0t: word with nothing due: %p", $realtime, out_word);
          mismatches++;
        end else begin
          want = levels_due.pop_front();
          if (out_word.front_left_level  !== want.front_left_level  ||
              out_word.front_right_level !== want.front_right_level ||
              out_word.side_left_level   !== want.side_left_level   ||
              out_word.side_right_level  !== want.side_right_level  ||
              out_word.center_error      !== want.center_error      ||
              out_word.calibration_done  !== want.calibration_done) begin
            if (mismatches < 10)
              $display("%0t: word %0d want fl=%0d fr=%0d sl=%0d sr=%0d err=%0d done=%0d",
                       $realtime, results_seen, want.front_left_level,
                       want.front_right_level, want.side_left_level, want.side_right_level,
                       want.center_error, want.calibration_done,
                       "\n    got fl=%0d fr=%0d sl=%0d sr=%0d err=%0d done=%0d",
                       out_word.front_left_level, out_word.front_right_level,
                       out_word.side_left_level, out_word.side_right_level,
                       out_word.center_error, out_word.calibration_done);
            mismatches++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen == 150) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= 300 && results_seen < 600) || $urandom_range(99) >= 26;
      end
    end
  end

  // Stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // default sample count: extremes, clamps, the centering ratio and two calibration words
    offer(reading_word(ACT_MEASURE, 0, 0, 0, 0, 0, 0, 0, 0));
    offer(reading_word(ACT_MEASURE, 0, 1023, 0, 1023, 0, 1023, 0, 1023));
    offer(reading_word(ACT_MEASURE, 1023, 0, 1023, 0, 1023, 0, 1023, 0));
    offer(reading_word(ACT_MEASURE, 5, 6, 700, 699, 0, 1023, 0, 0));
    offer(reading_word(ACT_MEASURE, 1023, 1023, 0, 1, 0, 0, 0, 1023));
    offer(reading_word(ACT_MEASURE, 0, 0, 0, 0, 0, 1, 0, 0));
    offer(reading_word(ACT_MEASURE, 512, 512, 1, 1, 300, 900, 0, 600));
    offer(reading_word(ACT_CALIBRATE, 0, 100, 0, 200, 0, 300, 0, 400));
    offer(reading_word(ACT_CALIBRATE, 0, 0, 0, 1023, 10, 15, 993, 1000));
    drain();

    // zero means one; count already past it, so the next calibration word completes
    load_cal_samples('0);
    offer(reading_word(ACT_CALIBRATE, 0, 50, 0, 60, 0, 70, 0, 80));
    offer(reading_word(ACT_MEASURE, 0, 100, 0, 259, 0, 376, 0, 1023));
    offer(reading_word(ACT_MEASURE, 0, 1023, 0, 1023, 0, 1023, 0, 1023));
    offer(reading_word(ACT_CALIBRATE, 0, 0, 0, 0, 0, 0, 0, 0));
    offer(reading_word(ACT_MEASURE, 20, 1000, 1000, 20, 7, 9, 9, 7));
    drain();

    // two-sample average with truncation
    load_cal_samples(11'd2);
    offer(reading_word(ACT_CALIBRATE, 0, 3, 0, 3, 0, 3, 0, 3));
    offer(reading_word(ACT_CALIBRATE, 0, 4, 0, 4, 0, 4, 0, 4));
    offer(reading_word(ACT_MEASURE, 0, 3, 0, 4, 0, 3, 0, 4));
    drain();

    // random rounds over several sample counts
    load_cal_samples(11'd1);
    random_batch(60, 50);
    load_cal_samples(11'd2047);
    random_batch(1070, 98);
    load_cal_samples(11'd1024);
    random_batch(40, 100);
    load_cal_samples(11'd5);
    random_batch(60, 60);
    load_cal_samples(11'd3);
    random_batch(150, 50);
    load_cal_samples(CAL_W'($urandom_range(40, 2)));
    random_batch(100, 70);
    load_cal_samples(CAL_SAMPLES_RESET);
    random_batch(60, 50);

    // let a stray word show up, then report
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
